// ----- sv/pcsc_pkg.sv -----
// Package for the PNG chunk stream checker: beat types, parse phase codes,
// error codes, the PNG signature table and the byte-wide CRC-32 step.
// No dependencies.
package pcsc_pkg;

   // Input beat: one file byte plus end-of-file flag.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   // Result beat: one verdict per file.
   typedef struct packed {
      logic       file_ok;
      logic [2:0] error_code;
   } rsp_payload_type;

   // Verdict handed from the parser to the output stage.
   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } verdict_type;

   // Parse phases.
   localparam logic [2:0] PhaseSig  = 3'd0;
   localparam logic [2:0] PhaseLen  = 3'd1;
   localparam logic [2:0] PhaseType = 3'd2;
   localparam logic [2:0] PhaseData = 3'd3;
   localparam logic [2:0] PhaseCrc  = 3'd4;
   localparam logic [2:0] PhaseDone = 3'd5;

   // Error codes.
   localparam logic [2:0] ErrNone      = 3'd0;
   localparam logic [2:0] ErrShort     = 3'd1;
   localparam logic [2:0] ErrSignature = 3'd2;
   localparam logic [2:0] ErrTruncated = 3'd3;
   localparam logic [2:0] ErrCrc       = 3'd4;
   localparam logic [2:0] ErrBadIend   = 3'd5;
   localparam logic [2:0] ErrNoIend    = 3'd6;

   localparam logic [5:0]  MinFileBytes = 6'd33;
   localparam logic [31:0] IendTag      = 32'h49454E44;
   localparam logic [31:0] CrcPoly      = 32'hEDB88320;
   localparam logic [31:0] CrcPreset    = 32'hFFFFFFFF;

   localparam logic [7:0] PngMagic [8] = '{
      8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
   };

   // Reflected CRC-32, one byte: eight shift/xor steps.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- sv/pcsc_parser.sv -----
// Chunk parser: holds the framing state, steps it once per accepted byte
// and produces the verdict on the last byte. Depends on pcsc_pkg.
module pcsc_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     beat_accept,
   input  pcsc_pkg::req_payload_type beat,
   output pcsc_pkg::verdict_type    verdict
);
   import pcsc_pkg::*;

   logic [5:0]  total_ff,  total_in;
   logic [2:0]  phase_ff,  phase_in;
   logic [2:0]  pos_ff,    pos_in;
   logic [31:0] len_ff,    len_in;
   logic [31:0] remain_ff, remain_in;
   logic [31:0] crc_ff,    crc_in;
   logic [31:0] tag_ff,    tag_in;
   logic [31:0] scrc_ff,   scrc_in;
   logic [2:0]  err_ff,    err_in;
   logic        end_ff,    end_in;
   logic [7:0]  b;
   logic [31:0] scrc_next;
   logic [2:0]  code;

   assign b         = beat.data_byte;
   assign scrc_next = {scrc_ff[23:0], b};

   always_comb begin
      total_in  = (total_ff < MinFileBytes) ? total_ff + 6'd1 : total_ff;
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      remain_in = remain_ff;
      crc_in    = crc_ff;
      tag_in    = tag_ff;
      scrc_in   = scrc_ff;
      err_in    = err_ff;
      end_in    = end_ff;
      // once an error is latched, only count bytes
      if (err_ff == ErrNone) begin
         case (phase_ff)
            PhaseSig: begin
               if (b != PngMagic[pos_ff]) err_in = ErrSignature;
               pos_in = pos_ff + 3'd1;
               if (pos_ff == 3'd7) begin
                  phase_in = PhaseLen;
                  pos_in   = 3'd0;
                  len_in   = '0;
               end
            end
            PhaseLen: begin
               len_in = {len_ff[23:0], b};
               pos_in = pos_ff + 3'd1;
               if (pos_ff == 3'd3) begin
                  phase_in = PhaseType;
                  pos_in   = 3'd0;
                  crc_in   = CrcPreset;
                  tag_in   = '0;
               end
            end
            PhaseType: begin
               crc_in = crc_byte(crc_ff, b);
               tag_in = {tag_ff[23:0], b};
               pos_in = pos_ff + 3'd1;
               if (pos_ff == 3'd3) begin
                  pos_in  = 3'd0;
                  scrc_in = '0;
                  if (len_ff == '0) begin
                     phase_in = PhaseCrc;
                  end else begin
                     phase_in  = PhaseData;
                     remain_in = len_ff;
                  end
               end
            end
            PhaseData: begin
               crc_in    = crc_byte(crc_ff, b);
               remain_in = remain_ff - 32'd1;
               if (remain_in == '0) begin
                  phase_in = PhaseCrc;
                  pos_in   = 3'd0;
                  scrc_in  = '0;
               end
            end
            PhaseCrc: begin
               scrc_in = scrc_next;
               pos_in  = pos_ff + 3'd1;
               if (pos_ff == 3'd3) begin
                  pos_in = 3'd0;
                  if (~crc_ff != scrc_next) begin
                     err_in = ErrCrc;
                  end else if (tag_ff == IendTag) begin
                     end_in   = 1'b1;
                     phase_in = PhaseDone;
                     if (len_ff != '0) err_in = ErrBadIend;
                  end else begin
                     phase_in = PhaseLen;
                     len_in   = '0;
                  end
               end
            end
            default: begin
               // anything after a complete IEND chunk
               err_in = ErrBadIend;
            end
         endcase
      end

      if (total_in < MinFileBytes)                   code = ErrShort;
      else if (err_in != ErrNone)                    code = err_in;
      else if (end_in)                               code = ErrNone;
      else if (phase_in == PhaseLen && pos_in == '0) code = ErrNoIend;
      else                                           code = ErrTruncated;
   end

   assign verdict.valid              = beat_accept && beat.last_byte;
   assign verdict.payload.file_ok    = (code == ErrNone);
   assign verdict.payload.error_code = code;

   always_ff @(posedge clock) begin
      if (reset || (beat_accept && beat.last_byte)) begin
         total_ff  <= '0;
         phase_ff  <= PhaseSig;
         pos_ff    <= '0;
         len_ff    <= '0;
         remain_ff <= '0;
         crc_ff    <= CrcPreset;
         tag_ff    <= '0;
         scrc_ff   <= '0;
         err_ff    <= ErrNone;
         end_ff    <= 1'b0;
      end else if (beat_accept) begin
         total_ff  <= total_in;
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         remain_ff <= remain_in;
         crc_ff    <= crc_in;
         tag_ff    <= tag_in;
         scrc_ff   <= scrc_in;
         err_ff    <= err_in;
         end_ff    <= end_in;
      end
   end

   // a latched error holds until the file ends
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff != ErrNone && !(beat_accept && beat.last_byte)) |=> err_ff == $past(err_ff))
      else $error("latched error changed mid-file");

   // field index stays inside the four-byte fields outside the signature
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PhaseSig |-> pos_ff < 3'd4)
      else $error("field position out of range");

   // done phase only after a good IEND CRC
   a_done_end: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PhaseDone |-> end_ff)
      else $error("done phase without IEND");

endmodule

// ----- sv/pcsc_out_stage.sv -----
// Result register: holds one verdict beat until the consumer takes it.
// Depends on pcsc_pkg.
module pcsc_out_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  pcsc_pkg::verdict_type     verdict,
   output logic                      slot_free,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output pcsc_pkg::rsp_payload_type rsp_payload
);
   import pcsc_pkg::*;

   logic            valid_ff;
   rsp_payload_type payload_ff;

   // a new verdict may load in the cycle the old one leaves
   assign slot_free   = !valid_ff || rsp_ready;
   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (verdict.valid) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (verdict.valid) payload_ff <= verdict.payload;
   end

   a_load: assert property (@(posedge clock) disable iff (reset)
      verdict.valid |=> valid_ff && payload_ff == $past(verdict.payload))
      else $error("verdict not loaded");

   a_ok_code: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> payload_ff.file_ok == (payload_ff.error_code == ErrNone))
      else $error("file_ok disagrees with error code");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      verdict.valid |-> slot_free)
      else $error("verdict overwrote a held beat");

endmodule

// ----- sv/png_chunk_stream_checker.sv -----
// Top level of the PNG chunk stream checker: parser plus result register.
// Depends on pcsc_pkg, pcsc_parser and pcsc_out_stage.
//
//   channel  dir  handshake            beat
//   req      in   req_valid/req_ready  one file byte, last_byte on the final one
//   rsp      out  rsp_valid/rsp_ready  file_ok and error_code, one per file
//
// One byte per cycle unless stalled; CRC-32 step and framing are combinational.
// A verdict appears on rsp the cycle after the last byte is taken.
// Synchronous reset clears the parse state and drops any held verdict.
// req_ready falls only while a verdict is held and rsp_ready is low.
module png_chunk_stream_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  pcsc_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output pcsc_pkg::rsp_payload_type rsp_payload
);
   import pcsc_pkg::*;

   verdict_type verdict;
   logic        slot_free;
   logic        req_accept;

   assign req_ready  = slot_free;
   assign req_accept = req_valid && req_ready;

   pcsc_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .beat_accept (req_accept),
      .beat        (req_payload),
      .verdict     (verdict)
   );

   pcsc_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .verdict     (verdict),
      .slot_free   (slot_free),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Testbench for png_chunk_stream_checker: directed and random PNG byte streams,
// each verdict checked against a listed code or an in-bench parser with its own CRC-32.
// Depends on pcsc_pkg and the png_chunk_stream_checker RTL.
module tb;
   import pcsc_pkg::*;

   localparam logic [31:0] IdatTag = 32'h49444154;
   localparam logic [31:0] TextTag = 32'h74455874;
   localparam int TotalBytes = 1650;

   typedef enum logic [3:0] {
      SHAPE_MIN_OK, SHAPE_ONE_BYTE, SHAPE_SHORT_BAD_SIG, SHAPE_ALL_ONES, SHAPE_BAD_SIG,
      SHAPE_BAD_CRC, SHAPE_IEND_BAD_CRC, SHAPE_IEND_LENGTH, SHAPE_TRAILING,
      SHAPE_CUT_HEADER, SHAPE_CUT_DATA, SHAPE_CUT_CRC, SHAPE_NO_IEND,
      SHAPE_HUGE_LENGTH, SHAPE_ZEROS
   } file_shape_type;

   typedef struct packed {
      file_shape_type shape;
      logic           listed;
      logic [2:0]     code;
   } directed_row_type;

   localparam directed_row_type DirectedRows [16] = '{
      '{SHAPE_MIN_OK,        1'b1, ErrNone},
      '{SHAPE_ONE_BYTE,      1'b1, ErrShort},
      '{SHAPE_SHORT_BAD_SIG, 1'b1, ErrShort},
      '{SHAPE_ALL_ONES,      1'b0, ErrNone},
      '{SHAPE_BAD_SIG,       1'b1, ErrSignature},
      '{SHAPE_BAD_CRC,       1'b1, ErrCrc},
      '{SHAPE_IEND_BAD_CRC,  1'b1, ErrCrc},
      '{SHAPE_IEND_LENGTH,   1'b1, ErrBadIend},
      '{SHAPE_TRAILING,      1'b1, ErrBadIend},
      '{SHAPE_CUT_HEADER,    1'b1, ErrTruncated},
      '{SHAPE_CUT_DATA,      1'b1, ErrTruncated},
      '{SHAPE_CUT_CRC,       1'b1, ErrTruncated},
      '{SHAPE_NO_IEND,       1'b1, ErrNoIend},
      '{SHAPE_HUGE_LENGTH,   1'b1, ErrTruncated},
      '{SHAPE_ZEROS,         1'b0, ErrNone},
      '{SHAPE_MIN_OK,        1'b0, ErrNone}
   };

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   png_chunk_stream_checker u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // Stimulus and expectations.
   logic [7:0]       file_buf [$];
   req_payload_type  stim_beats [$];
   directed_row_type listed_codes [$];   // one per file; listed = code typed in the table
   rsp_payload_type  verdicts_due [$];
   int               bytes_taken = 0;
   int               fails = 0;

   // Parser state of the predictor.
   logic [5:0]  seen_bytes;
   logic [2:0]  phase;
   int          field_idx;
   logic [31:0] len_acc;
   logic [31:0] data_left;
   logic [31:0] crc_acc;
   logic [31:0] tag_acc;
   logic [31:0] crc_field;
   logic [2:0]  err_latched;
   logic        iend_done;

   // Reflected CRC-32, one input bit per step.
   function automatic logic [31:0] crc32_next(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c;
      for (int i = 0; i < 8; i++) begin
         if (r[0] ^ b[i]) r = (r >> 1) ^ CrcPoly;
         else r = r >> 1;
      end
      return r;
   endfunction

   task automatic clear_parser();
      seen_bytes  = '0;
      phase       = PhaseSig;
      field_idx   = 0;
      len_acc     = '0;
      data_left   = '0;
      crc_acc     = CrcPreset;
      tag_acc     = '0;
      crc_field   = '0;
      err_latched = ErrNone;
      iend_done   = 1'b0;
   endtask

   task automatic absorb_byte(input req_payload_type beat, output bit due,
                              output rsp_payload_type verdict);
      logic [7:0] b;
      logic [2:0] code;
      b = beat.data_byte;
      due = 1'b0;
      verdict = '0;
      if (seen_bytes < MinFileBytes) seen_bytes++;
      if (err_latched == ErrNone) begin
         case (phase)
            PhaseSig: begin
               if (b != PngMagic[field_idx]) err_latched = ErrSignature;
               field_idx++;
               if (field_idx == 8) begin
                  phase = PhaseLen;
                  field_idx = 0;
                  len_acc = '0;
               end
            end
            PhaseLen: begin
               len_acc = {len_acc[23:0], b};
               field_idx++;
               if (field_idx == 4) begin
                  phase = PhaseType;
                  field_idx = 0;
                  crc_acc = CrcPreset;
                  tag_acc = '0;
               end
            end
            PhaseType: begin
               crc_acc = crc32_next(crc_acc, b);
               tag_acc = {tag_acc[23:0], b};
               field_idx++;
               if (field_idx == 4) begin
                  field_idx = 0;
                  crc_field = '0;
                  if (len_acc == 0) begin
                     phase = PhaseCrc;
                  end else begin
                     phase = PhaseData;
                     data_left = len_acc;
                  end
               end
            end
            PhaseData: begin
               crc_acc = crc32_next(crc_acc, b);
               data_left--;
               if (data_left == 0) begin
                  phase = PhaseCrc;
                  field_idx = 0;
                  crc_field = '0;
               end
            end
            PhaseCrc: begin
               crc_field = {crc_field[23:0], b};
               field_idx++;
               if (field_idx == 4) begin
                  field_idx = 0;
                  if (~crc_acc != crc_field) begin
                     err_latched = ErrCrc;
                  end else if (tag_acc == IendTag) begin
                     iend_done = 1'b1;
                     phase = PhaseDone;
                     if (len_acc != 0) err_latched = ErrBadIend;
                  end else begin
                     phase = PhaseLen;
                     len_acc = '0;
                  end
               end
            end
            default: err_latched = ErrBadIend;
         endcase
      end
      if (beat.last_byte) begin
         if (seen_bytes < MinFileBytes) code = ErrShort;
         else if (err_latched != ErrNone) code = err_latched;
         else if (iend_done) code = ErrNone;
         else if (phase == PhaseLen && field_idx == 0) code = ErrNoIend;
         else code = ErrTruncated;
         due = 1'b1;
         verdict.file_ok = (code == ErrNone);
         verdict.error_code = code;
         clear_parser();
      end
   endtask

   // File builders.
   task automatic put_sig();
      for (int i = 0; i < 8; i++) file_buf.push_back(PngMagic[i]);
   endtask

   task automatic put_chunk(input logic [31:0] len_field, input int n_data,
                            input logic [31:0] tag, input bit random_fill,
                            input logic [7:0] fill, input bit crc_good);
      logic [31:0] crc;
      logic [7:0]  d;
      crc = CrcPreset;
      for (int i = 3; i >= 0; i--) file_buf.push_back(len_field[8*i +: 8]);
      for (int i = 3; i >= 0; i--) begin
         file_buf.push_back(tag[8*i +: 8]);
         crc = crc32_next(crc, tag[8*i +: 8]);
      end
      for (int i = 0; i < n_data; i++) begin
         d = random_fill ? 8'($urandom) : fill;
         file_buf.push_back(d);
         crc = crc32_next(crc, d);
      end
      crc = ~crc;
      if (!crc_good) crc ^= 32'h1 << $urandom_range(0, 31);
      for (int i = 3; i >= 0; i--) file_buf.push_back(crc[8*i +: 8]);
   endtask

   task automatic queue_file(input logic listed, input logic [2:0] code);
      directed_row_type note;
      for (int i = 0; i < file_buf.size(); i++) begin
         stim_beats.push_back(req_payload_type'{data_byte: file_buf[i],
                                                last_byte: (i == file_buf.size() - 1)});
      end
      note.shape = SHAPE_MIN_OK;
      note.listed = listed;
      note.code = code;
      listed_codes.push_back(note);
   endtask

   task automatic build_directed(input file_shape_type shape);
      file_buf.delete();
      if (shape != SHAPE_ONE_BYTE && shape != SHAPE_ZEROS) put_sig();
      case (shape)
         SHAPE_MIN_OK: begin
            put_chunk(1, 1, TextTag, 1'b0, 8'h00, 1'b1);
            put_chunk(0, 0, IendTag, 1'b0, 8'h00, 1'b1);
         end
         SHAPE_ONE_BYTE: file_buf.push_back(8'hFF);
         SHAPE_SHORT_BAD_SIG: begin
            file_buf[0] = 8'h00;
            put_chunk(0, 0, TextTag, 1'b0, 8'h00, 1'b1);
            put_chunk(0, 0, IendTag, 1'b0, 8'h00, 1'b1);
         end
         SHAPE_ALL_ONES: begin
            put_chunk(9, 9, 32'hFFFFFFFF, 1'b0, 8'hFF, 1'b1);
            put_chunk(0, 0, IendTag, 1'b0, 8'h00, 1'b1);
         end
         SHAPE_HUGE_LENGTH: begin
            // ends deep inside the data of a maximum-length chunk
            put_chunk(32'hFFFFFFFF, 30, IdatTag, 1'b1, 8'h00, 1'b1);
         end
         SHAPE_CUT_DATA: begin
            put_chunk(30, 30, IdatTag, 1'b1, 8'h00, 1'b1);
            repeat (14) void'(file_buf.pop_back());
         end
         SHAPE_ZEROS: repeat (40) file_buf.push_back(8'h00);
         default: begin
            put_chunk(9, 9, IdatTag, 1'b1, 8'h00, shape != SHAPE_BAD_CRC);
            case (shape)
               SHAPE_BAD_CRC: begin
                  // later chunks are good; the first error stays latched
                  put_chunk(2, 2, IdatTag, 1'b1, 8'h00, 1'b1);
                  put_chunk(0, 0, IendTag, 1'b0, 8'h00, 1'b1);
               end
               SHAPE_IEND_BAD_CRC: put_chunk(0, 0, IendTag, 1'b0, 8'h00, 1'b0);
               SHAPE_IEND_LENGTH: put_chunk(1, 1, IendTag, 1'b1, 8'h00, 1'b1);
               SHAPE_NO_IEND: put_chunk(4, 4, IdatTag, 1'b1, 8'h00, 1'b1);
               default: put_chunk(0, 0, IendTag, 1'b0, 8'h00, 1'b1);
            endcase
            case (shape)
               SHAPE_BAD_SIG: file_buf[3] ^= 8'h20;
               SHAPE_TRAILING: file_buf.push_back(8'h00);
               SHAPE_CUT_HEADER: repeat (7) void'(file_buf.pop_back());
               SHAPE_CUT_CRC: repeat (2) void'(file_buf.pop_back());
               default: ;
            endcase
         end
      endcase
   endtask

   // Mostly well-formed files with random content; the rest damaged or noise.
   task automatic build_random();
      int n;
      int pick;
      int keep;
      file_buf.delete();
      put_sig();
      do begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 8);
         put_chunk(n, n, $urandom(), 1'b1, 8'h00, 1'b1);
      end while (file_buf.size() < 21 || ($urandom_range(0, 2) == 0 && file_buf.size() < 60));
      put_chunk(0, 0, IendTag, 1'b0, 8'h00, 1'b1);
      pick = $urandom_range(0, 99);
      if (pick >= 60 && pick < 70) begin
         keep = $urandom_range(0, file_buf.size() - 1);
         file_buf[keep] ^= 8'($urandom_range(1, 255));
      end else if (pick < 78 && pick >= 70) begin
         keep = $urandom_range(1, file_buf.size() - 1);
         while (file_buf.size() > keep) void'(file_buf.pop_back());
      end else if (pick < 84 && pick >= 78) begin
         repeat ($urandom_range(1, 4)) file_buf.push_back(8'($urandom));
      end else if (pick < 90 && pick >= 84) begin
         repeat (12) void'(file_buf.pop_back());
      end else if (pick < 94 && pick >= 90) begin
         repeat (12) void'(file_buf.pop_back());
         n = $urandom_range(1, 3);
         put_chunk(n, n, IendTag, 1'b1, 8'h00, 1'b1);
      end else if (pick >= 94) begin
         file_buf.delete();
         repeat ($urandom_range(1, 50)) file_buf.push_back(8'($urandom));
      end
   endtask

   // Sender: bursts of random length separated by random gaps.
   int stim_idx = 0;
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (stim_idx < stim_beats.size()) begin
            req_valid <= 1'b1;
            req_payload <= stim_beats[stim_idx];
            stim_idx++;
            if (burst_left == 0) begin
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 40);
               gap_left = $urandom_range(0, 8);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall modes picked again and again at random, plus two long
   // hold-offs so the held verdict backs up into the byte input.
   int hold_left = 0;
   int holds_done = 0;
   int hold_at = 400;
   int mode = 0;
   int mode_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_left == 0 && holds_done < 2 && bytes_taken >= hold_at) begin
            hold_left = 300;
            holds_done++;
            hold_at += 700;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 120);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   // Predict on every accepted byte beat.
   always @(posedge clock) begin : watch_req
      bit               due;
      rsp_payload_type  verdict;
      directed_row_type note;
      if (!reset && req_valid && req_ready) begin
         bytes_taken++;
         absorb_byte(req_payload, due, verdict);
         if (due) begin
            note = listed_codes.pop_front();
            if (note.listed) begin
               verdict.file_ok = (note.code == ErrNone);
               verdict.error_code = note.code;
            end
            verdicts_due.push_back(verdict);
         end
      end
   end

   // Compare every accepted verdict beat with the oldest expectation.
   always @(posedge clock) begin : watch_rsp
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdicts_due.size() == 0) begin
            $error("verdict with no file pending: file_ok %0d error_code %0d",
                   rsp_payload.file_ok, rsp_payload.error_code);
            fails++;
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_payload.file_ok !== want.file_ok) begin
               $error("file_ok: expected %0d, got %0d", want.file_ok, rsp_payload.file_ok);
               fails++;
            end
            if (rsp_payload.error_code !== want.error_code) begin
               $error("error_code: expected %0d, got %0d",
                      want.error_code, rsp_payload.error_code);
               fails++;
            end
         end
      end
   end

   initial begin
      int random_files;
      clear_parser();
      foreach (DirectedRows[i]) begin
         build_directed(DirectedRows[i].shape);
         queue_file(DirectedRows[i].listed, DirectedRows[i].code);
      end
      random_files = 0;
      while (stim_beats.size() < TotalBytes || random_files < 20) begin
         build_random();
         queue_file(1'b0, ErrNone);
         random_files++;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (bytes_taken < stim_beats.size()) @(posedge clock);
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fails == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
